FILE: sv/hk3_pkg.sv
// Package for the 3D Hilbert key core: orientation types, constants and the
// per-level digit and orientation functions. No dependencies.
package hk3_pkg;

  // Default number of curve levels (coordinate bits used per axis).
  localparam int COORD_BITS_DEF = 32;
  // Width of each coordinate and key word on the ports.
  localparam int WORD_BITS = 32;
  // Full key width: three key words.
  localparam int KEY_BITS = 3 * WORD_BITS;
  // Number of axes.
  localparam int AXES = 3;

  // Axis codes held in the upper two bits of an orientation entry.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // One orientation entry: axis number in [2:1], inversion flag in [0].
  typedef logic [2:0] orient_t;
  // Orientation of all three digit positions; element n serves Gray code bit n.
  typedef orient_t [AXES-1:0] orient_set_t;

  // Orientation at the top level of the curve.
  localparam orient_set_t ORIENT_INIT = '{{AXIS_Z, 1'b0}, {AXIS_Y, 1'b0}, {AXIS_X, 1'b0}};

  // Select one coordinate bit by axis number; an unused axis code reads zero.
  function automatic logic pick_bit(input logic [AXES-1:0] bits, input logic [1:0] sel);
    logic b;
    case (sel)
      AXIS_X:  b = bits[0];
      AXIS_Y:  b = bits[1];
      AXIS_Z:  b = bits[2];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

  // Inverse 3-bit Gray code.
  function automatic logic [2:0] inv_gray(input logic [2:0] g);
    logic [2:0] d;
    case (g)
      3'd0:    d = 3'd0;
      3'd1:    d = 3'd1;
      3'd2:    d = 3'd3;
      3'd3:    d = 3'd2;
      3'd4:    d = 3'd7;
      3'd5:    d = 3'd6;
      3'd6:    d = 3'd4;
      3'd7:    d = 3'd5;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

  // Orientation after a level, chosen by that level's digit.
  function automatic orient_set_t next_orient(input orient_set_t o, input logic [2:0] d);
    orient_set_t n;
    n = o;
    case (d)
      3'd0: begin
        n[0] = o[2];          n[1] = o[1];          n[2] = o[0];
      end
      3'd1: begin
        n[0] = o[0];          n[1] = o[2];          n[2] = o[1];
      end
      3'd3: begin
        n[0] = o[2] ^ 3'd1;   n[1] = o[0] ^ 3'd1;   n[2] = o[1];
      end
      3'd4: begin
        n[0] = o[2];          n[1] = o[0] ^ 3'd1;   n[2] = o[1] ^ 3'd1;
      end
      3'd6: begin
        n[0] = o[0];          n[1] = o[2] ^ 3'd1;   n[2] = o[1] ^ 3'd1;
      end
      3'd7: begin
        n[0] = o[2] ^ 3'd1;   n[1] = o[1];          n[2] = o[0] ^ 3'd1;
      end
      // Digits 2 and 5 keep the orientation.
      default: n = o;
    endcase
    return n;
  endfunction

endpackage

FILE: sv/hilbert_key_3d_core.sv
// Top level of the 3D Hilbert key core: a chain of hk3_cell stages, one per
// curve level. Uses hk3_pkg and hk3_cell.
//
// The core maps a point of three unsigned coordinates to its 96-bit Hilbert
// curve index, returned as three 32-bit words, most significant first. Only
// the low COORD_BITS bits of each coordinate are used; the 3*COORD_BITS key
// bits sit at the top of the key and the bits below them are zero. The core
// takes one point per clock cycle while the result port is not stalled. A
// point passes through one register in each level cell of the chain; the
// last cell's register drives the result ports. Each cell holds its request
// until the next cell takes it, so a stalled result port fills empty cells
// first and only then stops accepting input.
module hilbert_key_3d_core #(
  parameter int COORD_BITS = hk3_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hk3_pkg::WORD_BITS-1:0]  in_x_coord,
  input  logic [hk3_pkg::WORD_BITS-1:0]  in_y_coord,
  input  logic [hk3_pkg::WORD_BITS-1:0]  in_z_coord,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hk3_pkg::WORD_BITS-1:0]  out_key_high,
  output logic [hk3_pkg::WORD_BITS-1:0]  out_key_mid,
  output logic [hk3_pkg::WORD_BITS-1:0]  out_key_low
);

  localparam int KW = 3 * COORD_BITS;
  localparam int WB = hk3_pkg::WORD_BITS;

  // Links between cells; link 0 is the input, link COORD_BITS the output.
  logic                       lk_valid [COORD_BITS+1];
  logic                       lk_ready [COORD_BITS+1];
  logic [COORD_BITS-1:0]      lk_x     [COORD_BITS+1];
  logic [COORD_BITS-1:0]      lk_y     [COORD_BITS+1];
  logic [COORD_BITS-1:0]      lk_z     [COORD_BITS+1];
  hk3_pkg::orient_set_t       lk_orient[COORD_BITS+1];
  logic [KW-1:0]              lk_key   [COORD_BITS+1];
  logic [hk3_pkg::KEY_BITS-1:0] key_full;

  // Input request enters the first cell with the top-level orientation.
  assign lk_valid[0]  = in_valid;
  assign in_ready     = lk_ready[0];
  assign lk_x[0]      = in_x_coord[COORD_BITS-1:0];
  assign lk_y[0]      = in_y_coord[COORD_BITS-1:0];
  assign lk_z[0]      = in_z_coord[COORD_BITS-1:0];
  assign lk_orient[0] = hk3_pkg::ORIENT_INIT;
  assign lk_key[0]    = '0;

  // One cell per level, top coordinate bit first.
  for (genvar l = 1; l <= COORD_BITS; l++) begin : g_cell
    hk3_cell #(
      .COORD_BITS (COORD_BITS),
      .LEVEL      (l)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (lk_valid[l-1]),
      .up_ready  (lk_ready[l-1]),
      .up_x      (lk_x[l-1]),
      .up_y      (lk_y[l-1]),
      .up_z      (lk_z[l-1]),
      .up_orient (lk_orient[l-1]),
      .up_key    (lk_key[l-1]),
      .dn_valid  (lk_valid[l]),
      .dn_ready  (lk_ready[l]),
      .dn_x      (lk_x[l]),
      .dn_y      (lk_y[l]),
      .dn_z      (lk_z[l]),
      .dn_orient (lk_orient[l]),
      .dn_key    (lk_key[l])
    );
  end

  // The last cell's register is the result register.
  assign out_valid            = lk_valid[COORD_BITS];
  assign lk_ready[COORD_BITS] = out_ready;

  // Key digits sit at the top of the full key; lower bits are zero.
  assign key_full     = hk3_pkg::KEY_BITS'(lk_key[COORD_BITS]) << (hk3_pkg::KEY_BITS - KW);
  assign out_key_high = key_full[3*WB-1 -: WB];
  assign out_key_mid  = key_full[2*WB-1 -: WB];
  assign out_key_low  = key_full[WB-1 -: WB];

endmodule

FILE: sv/hk3_cell.sv
// One level cell of the Hilbert key chain: forms one 3-bit digit and the next
// orientation, and registers the request for the next cell. Uses hk3_pkg.
module hk3_cell #(
  parameter int COORD_BITS = hk3_pkg::COORD_BITS_DEF,
  parameter int LEVEL      = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Upstream side.
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [COORD_BITS-1:0]       up_x,
  input  logic [COORD_BITS-1:0]       up_y,
  input  logic [COORD_BITS-1:0]       up_z,
  input  hk3_pkg::orient_set_t        up_orient,
  input  logic [3*COORD_BITS-1:0]     up_key,
  // Downstream side.
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [COORD_BITS-1:0]       dn_x,
  output logic [COORD_BITS-1:0]       dn_y,
  output logic [COORD_BITS-1:0]       dn_z,
  output hk3_pkg::orient_set_t        dn_orient,
  output logic [3*COORD_BITS-1:0]     dn_key
);

  // Coordinate bit used at this level and key slot filled by it.
  localparam int SHIFT = COORD_BITS - LEVEL;
  localparam int POS   = 3 * COORD_BITS - 1 - 3 * (LEVEL - 1);

  logic                       valid_r;
  logic [COORD_BITS-1:0]      x_r, y_r, z_r;
  hk3_pkg::orient_set_t       orient_r, orient_nxt;
  logic [3*COORD_BITS-1:0]    key_r, key_nxt;
  logic [2:0]                 gray;
  logic [2:0]                 digit;
  logic [2:0]                 level_bits;
  logic                       load;

  // Gather one bit per digit position under the current orientation.
  always_comb begin
    level_bits = {up_z[SHIFT], up_y[SHIFT], up_x[SHIFT]};
    for (int n = 0; n < hk3_pkg::AXES; n++) begin
      gray[n] = hk3_pkg::pick_bit(level_bits, up_orient[n][2:1]) ^ up_orient[n][0];
    end
    digit      = hk3_pkg::inv_gray(gray);
    orient_nxt = hk3_pkg::next_orient(up_orient, digit);
    key_nxt    = up_key;
    key_nxt[POS -: 3] = digit;
  end

  // The stage takes a new request when empty or when its own is leaving.
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r      <= up_x;
      y_r      <= up_y;
      z_r      <= up_z;
      orient_r <= orient_nxt;
      key_r    <= key_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_x      = x_r;
  assign dn_y      = y_r;
  assign dn_z      = z_r;
  assign dn_orient = orient_r;
  assign dn_key    = key_r;

endmodule
